// ----- src/cng_pkg.sv -----
package cng_pkg;

    // Hardware limit on pins: the column word and the pin field fix it
    localparam int HW_PINS   = 32;

    localparam int PIN_W     = 5;
    localparam int COL_W     = 32;
    localparam int NODE_W    = 6;
    localparam int COUNT_W   = 5;
    localparam int CFG_W     = 6;

    localparam logic [CFG_W-1:0]  CFG_RESET = 6'd32;
    localparam logic [NODE_W-1:0] NODE_NONE = 6'h3F;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    // Input tdata: pin_index, column_bits, padded to whole bytes
    localparam int S_PIN_LO   = 0;
    localparam int S_COL_LO   = S_PIN_LO + PIN_W;
    localparam int S_TDATA_W  = ((S_COL_LO + COL_W + 7) / 8) * 8;

    // Output tdata: out_pin, node_id, node_count
    localparam int M_PIN_LO   = 0;
    localparam int M_NODE_LO  = M_PIN_LO + PIN_W;
    localparam int M_COUNT_LO = M_NODE_LO + NODE_W;
    localparam int M_TDATA_W  = ((M_COUNT_LO + COUNT_W + 7) / 8) * 8;

endpackage

// ----- src/circuit_node_grouper.sv -----
// Load request: column written to the connection memory when accepted.
// Run request: scan of pins 0..n-3; a checked pin is skipped, an unchecked pin
// takes a memory read then an evaluate, and each further node member is written.
// Results leave at one per cycle when not stalled, via read and output registers.
// Reset is synchronous, active low: clears control, pin_count to 32; the
// connection memory holds no defined value until loaded.
module circuit_node_grouper #(
    parameter int MAX_PINS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config write: pin_count
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cng_pkg::CFG_W-1:0]           cfg_data,
    // input requests
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata, from bit 0: pin_index[4:0], column_bits[31:0], zero pad
    input  logic [cng_pkg::S_TDATA_W-1:0]       s_tdata,
    // tuser: op
    input  logic [0:0]                          s_tuser,
    // results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata, from bit 0: out_pin[4:0], node_id[5:0], node_count[4:0]
    output logic [cng_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast
);

    localparam int PINS  = (MAX_PINS < cng_pkg::HW_PINS) ? MAX_PINS : cng_pkg::HW_PINS;
    localparam int IDX_W = $clog2(PINS);
    localparam int CNT_W = $clog2(PINS + 1);
    localparam int CW1   = CNT_W + 1;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SCAN_RD   = 3'd1;
    localparam logic [2:0] ST_SCAN_EVAL = 3'd2;
    localparam logic [2:0] ST_SCAN_WR   = 3'd3;
    localparam logic [2:0] ST_EMIT      = 3'd4;

    logic [2:0]                     state_reg, state_next;
    logic [cng_pkg::CFG_W-1:0]      pin_count_reg;
    logic [CNT_W-1:0]               n_reg, n_next, n_eff;
    logic [IDX_W-1:0]               i_reg, i_next;
    logic [CNT_W-1:0]               k_reg, k_next;
    logic [PINS-1:0]                checked_reg, checked_next;
    logic [PINS-1:0]                valid_reg, valid_next;
    logic [PINS-1:0]                mask_reg, mask_next;
    logic [cng_pkg::COUNT_W-1:0]    nf_reg, nf_next;

    logic [PINS-1:0]                conn_mem [PINS];
    logic [PINS-1:0]                conn_rdata_reg;
    logic                           conn_rd_en;

    logic [cng_pkg::NODE_W-1:0]     node_mem [PINS];
    logic [cng_pkg::NODE_W-1:0]     node_rdata_reg;
    logic                           node_we;
    logic [IDX_W-1:0]               node_waddr;

    logic                           pend_reg, pend_next;
    logic [IDX_W-1:0]               pend_pin_reg;
    logic                           pend_last_reg;
    logic                           pend_valid_reg;
    logic [cng_pkg::COUNT_W-1:0]    pend_count_reg;

    logic                           out_valid_reg;
    logic [cng_pkg::M_TDATA_W-1:0]  out_data_reg;
    logic                           out_last_reg;

    logic                           accept, load_out, issue;
    logic [cng_pkg::PIN_W-1:0]      in_pin;
    logic [cng_pkg::COL_W-1:0]      in_col;
    logic                           in_load_ok;
    logic [PINS-1:0]                range_mask, cand_mask, pin_bit;
    logic                           cand_one, scan_done;
    logic [IDX_W-1:0]               low_idx;
    logic [PINS-1:0]                low_bit;
    logic [cng_pkg::NODE_W-1:0]     node_out;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;

    assign in_pin     = s_tdata[cng_pkg::S_PIN_LO +: cng_pkg::PIN_W];
    assign in_col     = s_tdata[cng_pkg::S_COL_LO +: cng_pkg::COL_W];
    assign in_load_ok = ({1'b0, in_pin} < 6'(PINS));

    assign n_eff = (pin_count_reg > 6'(PINS)) ? CNT_W'(PINS) : CNT_W'(pin_count_reg);

    assign scan_done  = (CW1'(i_reg) + CW1'(2)) >= CW1'(n_reg);
    assign pin_bit    = PINS'(1) << i_reg;
    assign range_mask = (({PINS{1'b1}} << i_reg) << 1) & ~({PINS{1'b1}} << n_reg);
    assign cand_mask  = conn_rdata_reg & ~checked_reg & range_mask;
    assign cand_one   = ((cand_mask & (cand_mask - PINS'(1))) == '0);

    // lowest pending member of the node being written
    always_comb begin
        low_idx = '0;
        for (int b = PINS - 1; b >= 0; b--) begin
            if (mask_reg[b]) begin
                low_idx = IDX_W'(b);
            end
        end
    end
    assign low_bit = PINS'(1) << low_idx;

    assign load_out = pend_reg && (!out_valid_reg || m_tready);
    assign issue    = (state_reg == ST_EMIT) && (k_reg < n_reg) && (!pend_reg || load_out);

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        k_next       = k_reg;
        checked_next = checked_reg;
        valid_next   = valid_reg;
        mask_next    = mask_reg;
        nf_next      = nf_reg;
        conn_rd_en   = 1'b0;
        node_we      = 1'b0;
        node_waddr   = i_reg;
        pend_next    = pend_reg;

        if (load_out) begin
            pend_next = 1'b0;
        end
        if (issue) begin
            pend_next = 1'b1;
            k_next    = k_reg + CNT_W'(1);
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_tuser[0] == cng_pkg::OP_RUN)) begin
                    n_next       = n_eff;
                    i_next       = '0;
                    k_next       = '0;
                    checked_next = '0;
                    valid_next   = '0;
                    nf_next      = '0;
                    state_next   = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                priority if (scan_done) begin
                    state_next = ST_EMIT;
                end else if (checked_reg[i_reg]) begin
                    i_next = i_reg + IDX_W'(1);
                end else begin
                    conn_rd_en = 1'b1;
                    state_next = ST_SCAN_EVAL;
                end
            end
            ST_SCAN_EVAL: begin
                priority if (cand_mask == '0) begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = ST_SCAN_RD;
                end else if (cand_one) begin
                    // a lone pair: check both, no node
                    checked_next = checked_reg | pin_bit | cand_mask;
                    i_next       = i_reg + IDX_W'(1);
                    state_next   = ST_SCAN_RD;
                end else begin
                    checked_next = checked_reg | pin_bit | cand_mask;
                    node_we      = 1'b1;
                    node_waddr   = i_reg;
                    valid_next   = valid_reg | pin_bit;
                    mask_next    = cand_mask;
                    state_next   = ST_SCAN_WR;
                end
            end
            ST_SCAN_WR: begin
                node_we    = 1'b1;
                node_waddr = low_idx;
                valid_next = valid_reg | low_bit;
                mask_next  = mask_reg & ~low_bit;
                if ((mask_reg & ~low_bit) == '0) begin
                    nf_next    = nf_reg + cng_pkg::COUNT_W'(1);
                    i_next     = i_reg + IDX_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_EMIT: begin
                if (k_reg >= n_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pin_count_reg <= cng_pkg::CFG_RESET;
            n_reg         <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            checked_reg   <= '0;
            valid_reg     <= '0;
            mask_reg      <= '0;
            nf_reg        <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            i_reg       <= i_next;
            k_reg       <= k_next;
            checked_reg <= checked_next;
            valid_reg   <= valid_next;
            mask_reg    <= mask_next;
            nf_reg      <= nf_next;
            pend_reg    <= pend_next;
            if (cfg_valid && cfg_ready) begin
                pin_count_reg <= cfg_data;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // connection memory: written on load, read during the scan
    always_ff @(posedge aclk) begin
        if (accept && (s_tuser[0] == cng_pkg::OP_LOAD) && in_load_ok) begin
            conn_mem[in_pin[IDX_W-1:0]] <= in_col[PINS-1:0];
        end
        if (conn_rd_en) begin
            conn_rdata_reg <= conn_mem[i_reg];
        end
    end

    // node memory: written during the scan, read during emission
    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[node_waddr] <= {1'b0, nf_reg};
        end
        if (issue) begin
            node_rdata_reg <= node_mem[k_reg[IDX_W-1:0]];
        end
    end

    // capture side data with the read, so a following run cannot disturb it
    always_ff @(posedge aclk) begin
        if (issue) begin
            pend_pin_reg   <= k_reg[IDX_W-1:0];
            pend_last_reg  <= (k_reg + CNT_W'(1)) == n_reg;
            pend_valid_reg <= valid_reg[k_reg[IDX_W-1:0]];
            pend_count_reg <= nf_reg;
        end
    end

    assign node_out = pend_valid_reg ? node_rdata_reg : cng_pkg::NODE_NONE;

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= cng_pkg::M_TDATA_W'({pend_count_reg, node_out,
                                                cng_pkg::PIN_W'(pend_pin_reg)});
            out_last_reg <= pend_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- src/cng_checker.sv -----
module cng_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [cng_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                m_tlast
);

    logic [cng_pkg::PIN_W-1:0]   out_pin;
    logic [cng_pkg::NODE_W-1:0]  node_id;
    logic [cng_pkg::COUNT_W-1:0] node_count;
    logic                        out_take;

    assign out_pin    = m_tdata[cng_pkg::M_PIN_LO +: cng_pkg::PIN_W];
    assign node_id    = m_tdata[cng_pkg::M_NODE_LO +: cng_pkg::NODE_W];
    assign node_count = m_tdata[cng_pkg::M_COUNT_LO +: cng_pkg::COUNT_W];
    assign out_take   = m_tvalid && m_tready;

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

    // advance the pin number by one within a run
    a_pin_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_take && !m_tlast) |=> (!m_tvalid || (out_pin == $past(out_pin) + 5'd1)))
        else $error("pin sequence broken");

    a_count_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_take && !m_tlast) |=> (!m_tvalid || (node_count == $past(node_count))))
        else $error("node count changed within a run");

    a_node_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((node_id == cng_pkg::NODE_NONE) ||
                      (!node_id[cng_pkg::NODE_W-1] &&
                       (node_id[cng_pkg::COUNT_W-1:0] < node_count))))
        else $error("node number out of range");

endmodule

bind circuit_node_grouper cng_checker u_cng_checker (.*);
